// ===== rtl/core/pwfl_pkg.sv =====
// Shared types and constants for the piecewise linear floor lookup.
// Holds the operation and status codes, the table entry layout and the
// command and status structs between the controller and the datapath.
package pwfl_pkg;

    // Fraction bits of the Q16.16 coordinates and of the Q1.16 ratio.
    localparam int FRAC = 16;

    // Step counter shared by the divider and the interpolation sequence.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] DIV_LAST  = 5'd16;
    localparam logic [STEP_W-1:0] LERP_LAST = 5'd3;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_FULL   = 3'd1,
        ST_INTERP = 3'd2,
        ST_HOLD   = 3'd3,
        ST_NOSEG  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DIV,
        S_LMUL,
        S_LADD,
        S_DONE
    } state_t;

    // How the result registers are loaded.
    typedef enum logic [2:0] {
        RK_KEEP,
        RK_PLAIN,
        RK_NOSEG,
        RK_HOLD,
        RK_INTERP
    } res_kind_t;

    // Which breakpoint value is being interpolated.
    typedef enum logic [1:0] {
        LERP_Y  = 2'd0,
        LERP_H  = 2'd1,
        LERP_LO = 2'd2,
        LERP_HI = 2'd3
    } lerp_sel_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
        logic [15:0] slo;
        logic [15:0] shi;
    } entry_t;

    typedef struct packed {
        logic      load;
        logic      append;
        logic      clear;
        logic      rd_first;
        logic      scan_adv;
        logic      seg_latch;
        logic      div_step;
        logic      lerp_mul;
        logic      lerp_add;
        lerp_sel_t sel;
        res_kind_t res_kind;
        status_t   res_status;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       empty;
        logic       full;
        logic       x_lt;
        logic       idx_zero;
        logic       idx_last;
        logic       out_free;
    } sts_t;

endpackage

// ===== rtl/core/piecewise_linear_floor_lookup.sv =====
// Top level of the piecewise linear floor lookup: configuration registers
// and the connection of controller and datapath. Depends on pwfl_pkg,
// pwfl_ctrl and pwfl_dp.
//
// Usage. Requests enter on the in_valid / in_ready channel: append a
// breakpoint, clear the table, or query the floor at coord_x. Every append,
// clear and query gives exactly one result on out_valid / out_ready; an
// operation code of 3 is dropped without a result. origin_x and origin_y
// are written over the APB-style port at byte addresses 0 and 4 and may be
// changed only while no request is in flight.
// Sequence: append and clear pass through EXEC and DONE to out_valid. A
// query passes through EXEC, scans the breakpoints and, when it interpolates,
// runs 17 divider steps, then 4 multiply and add pairs on one shared
// multiplier, before DONE. The scan is bounded by the single read port of
// the table memory, which delivers one breakpoint per cycle.
// One request is worked on at a time; in_ready returns as soon as its
// result has moved into the output register, so a new request is taken
// while the receiver still stalls on the previous result. The next result
// waits inside the block until the output register is taken.
// Reset empties the table (no clearing pass), drops any pending result and
// clears both origins to zero.
module piecewise_linear_floor_lookup #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // Request channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_height,
    input  logic [15:0]        point_scale_low,
    input  logic [15:0]        point_scale_high,
    // Result channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] floor_y,
    output logic signed [31:0] floor_height,
    output logic [15:0]        scale_low_out,
    output logic [15:0]        scale_high_out,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [31:0]     origin_x_reg, origin_x_next;
    logic [31:0]     origin_y_reg, origin_y_next;
    logic            cfg_write;
    pwfl_pkg::cmd_t  cmd;
    pwfl_pkg::sts_t  sts;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Register index is address bit 2; the two low bits are ignored.
    always_comb
    begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                pwfl_pkg::REG_ORIGIN_X: origin_x_next = pwdata;
                pwfl_pkg::REG_ORIGIN_Y: origin_y_next = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else
        begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pwfl_pkg::REG_ORIGIN_X: prdata = origin_x_reg;
            pwfl_pkg::REG_ORIGIN_Y: prdata = origin_y_reg;
            default:                prdata = '0;
        endcase
    end

    pwfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwfl_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .operation        (operation),
        .coord_x          (coord_x),
        .point_y          (point_y),
        .point_height     (point_height),
        .point_scale_low  (point_scale_low),
        .point_scale_high (point_scale_high),
        .origin_x         (origin_x_reg),
        .origin_y         (origin_y_reg),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .floor_y          (floor_y),
        .floor_height     (floor_height),
        .scale_low_out    (scale_low_out),
        .scale_high_out   (scale_high_out)
    );

endmodule

// ===== rtl/core/pwfl_ctrl.sv =====
// Controller state machine of the piecewise linear floor lookup.
// Depends on pwfl_pkg for the state, command and status types.
module pwfl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pwfl_pkg::sts_t sts,
    output pwfl_pkg::cmd_t cmd
);

    pwfl_pkg::state_t                 state_reg, state_next;
    logic [pwfl_pkg::STEP_W-1:0]      step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwfl_pkg::S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            pwfl_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = pwfl_pkg::S_EXEC;
            end
            pwfl_pkg::S_EXEC:
            begin
                unique case (sts.op) inside
                    pwfl_pkg::OP_APPEND, pwfl_pkg::OP_CLEAR:
                        state_next = pwfl_pkg::S_DONE;
                    pwfl_pkg::OP_QUERY:
                        state_next = sts.empty ? pwfl_pkg::S_DONE : pwfl_pkg::S_SCAN;
                    default:
                        state_next = pwfl_pkg::S_IDLE;
                endcase
            end
            pwfl_pkg::S_SCAN:
            begin
                if (sts.x_lt && !sts.idx_last)
                    state_next = pwfl_pkg::S_SCAN;
                else if (sts.x_lt || sts.idx_zero)
                    state_next = pwfl_pkg::S_DONE;
                else
                begin
                    state_next = pwfl_pkg::S_DIV;
                    step_next  = '0;
                end
            end
            pwfl_pkg::S_DIV:
            begin
                if (step_reg == pwfl_pkg::DIV_LAST)
                begin
                    state_next = pwfl_pkg::S_LMUL;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            pwfl_pkg::S_LMUL:
                state_next = pwfl_pkg::S_LADD;
            pwfl_pkg::S_LADD:
            begin
                if (step_reg == pwfl_pkg::LERP_LAST)
                    state_next = pwfl_pkg::S_DONE;
                else
                begin
                    state_next = pwfl_pkg::S_LMUL;
                    step_next  = step_reg + 1'b1;
                end
            end
            pwfl_pkg::S_DONE:
            begin
                if (sts.out_free)
                    state_next = pwfl_pkg::S_IDLE;
            end
            default:
                state_next = pwfl_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd            = '0;
        cmd.res_kind   = pwfl_pkg::RK_KEEP;
        cmd.res_status = pwfl_pkg::ST_DONE;
        cmd.sel        = pwfl_pkg::lerp_sel_t'(step_reg[1:0]);
        in_ready       = 1'b0;
        unique case (state_reg)
            pwfl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pwfl_pkg::S_EXEC:
            begin
                unique case (sts.op) inside
                    pwfl_pkg::OP_APPEND:
                    begin
                        cmd.append     = 1'b1;
                        cmd.res_kind   = pwfl_pkg::RK_PLAIN;
                        cmd.res_status = sts.full ? pwfl_pkg::ST_FULL : pwfl_pkg::ST_DONE;
                    end
                    pwfl_pkg::OP_CLEAR:
                    begin
                        cmd.clear    = 1'b1;
                        cmd.res_kind = pwfl_pkg::RK_PLAIN;
                    end
                    pwfl_pkg::OP_QUERY:
                    begin
                        if (sts.empty)
                            cmd.res_kind = pwfl_pkg::RK_NOSEG;
                        else
                            cmd.rd_first = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            pwfl_pkg::S_SCAN:
            begin
                if (sts.x_lt && !sts.idx_last)
                    cmd.scan_adv = 1'b1;
                else if (sts.x_lt)
                    cmd.res_kind = pwfl_pkg::RK_HOLD;
                else if (sts.idx_zero)
                    cmd.res_kind = pwfl_pkg::RK_NOSEG;
                else
                begin
                    cmd.seg_latch = 1'b1;
                    cmd.res_kind  = pwfl_pkg::RK_INTERP;
                end
            end
            pwfl_pkg::S_DIV:
                cmd.div_step = 1'b1;
            pwfl_pkg::S_LMUL:
                cmd.lerp_mul = 1'b1;
            pwfl_pkg::S_LADD:
                cmd.lerp_add = 1'b1;
            pwfl_pkg::S_DONE:
                cmd.out_load = sts.out_free;
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The divider step counter stays within its seventeen steps, 0 to DIV_LAST.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pwfl_pkg::S_DIV) |-> (step_reg <= pwfl_pkg::DIV_LAST))
        else $error("divider step counter out of range");

    // A result is only moved to the output register when that register is free.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

// ===== rtl/core/pwfl_dp.sv =====
// Datapath of the piecewise linear floor lookup: breakpoint memory, scan,
// restoring divider, shared interpolation multiplier and result registers.
// Depends on pwfl_pkg for the entry layout and the command and status types.
module pwfl_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         operation,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_height,
    input  logic [15:0]        point_scale_low,
    input  logic [15:0]        point_scale_high,
    input  logic [31:0]        origin_x,
    input  logic [31:0]        origin_y,
    input  pwfl_pkg::cmd_t     cmd,
    output pwfl_pkg::sts_t     sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] floor_y,
    output logic signed [31:0] floor_height,
    output logic [15:0]        scale_low_out,
    output logic [15:0]        scale_high_out
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Request registers.
    logic [1:0]               op_reg;
    pwfl_pkg::entry_t         req_reg;
    logic signed [32:0]       q_reg;
    logic signed [32:0]       q_next;

    // Table state.
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            raddr;
    logic [CW-1:0]            idx_inc;
    logic                     full;
    pwfl_pkg::entry_t         mem [MAX_POINTS];
    pwfl_pkg::entry_t         rdata_reg;
    pwfl_pkg::entry_t         prev_reg;
    pwfl_pkg::entry_t         cur_reg;

    // Divider.
    logic [32:0]              rem_reg;
    logic [31:0]              den_reg;
    logic [16:0]              quo_reg;
    logic signed [32:0]       num_seg;
    logic signed [32:0]       den_seg;
    logic                     div_ge;
    logic [32:0]              rem_sub;

    // Interpolation.
    logic signed [32:0]       lerp_a, lerp_b, lerp_diff, lerp_sum;
    logic signed [50:0]       prod_reg, prod_next;
    logic signed [50:0]       lerp_shift;
    logic signed [33:0]       y_sum;
    logic signed [33:0]       hold_sum;

    // Result and output registers.
    logic [2:0]               res_status_reg;
    logic [31:0]              res_y_reg, res_h_reg;
    logic [15:0]              res_lo_reg, res_hi_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [2:0]               out_status_reg;
    logic [31:0]              out_y_reg, out_h_reg;
    logic [15:0]              out_lo_reg, out_hi_reg;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign q_next = $signed({coord_x[31], coord_x}) - $signed({origin_x[31], origin_x});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            req_reg.x   <= coord_x;
            req_reg.y   <= point_y;
            req_reg.h   <= point_height;
            req_reg.slo <= point_scale_low;
            req_reg.shi <= point_scale_high;
            q_reg       <= q_next;
        end
    end

    // Fill count.
    assign full    = (count_reg == CW'(MAX_POINTS));
    assign idx_inc = CW'(idx_reg) + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
            count_next = '0;
        else if (cmd.append && !full)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Breakpoint memory with one write and one registered read per cycle.
    always_comb
    begin
        if (cmd.rd_first)
            raddr = '0;
        else if (cmd.scan_adv)
            raddr = idx_reg + 1'b1;
        else
            raddr = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
            mem[count_reg[IW-1:0]] <= req_reg;
        rdata_reg <= mem[raddr];
    end

    // Scan position and segment end points.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_first)
            idx_reg <= '0;
        else if (cmd.scan_adv)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.scan_adv)
            prev_reg <= rdata_reg;
        if (cmd.seg_latch)
            cur_reg <= rdata_reg;
    end

    assign sts.op       = op_reg;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = full;
    assign sts.x_lt     = $signed({rdata_reg.x[31], rdata_reg.x}) < q_reg;
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.idx_last = (idx_inc >= count_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Restoring divider: ratio = (q - P.x) * 2^16 / (C.x - P.x), one bit a step.
    assign num_seg = q_reg - $signed({prev_reg.x[31], prev_reg.x});
    assign den_seg = $signed({rdata_reg.x[31], rdata_reg.x})
                   - $signed({prev_reg.x[31], prev_reg.x});
    assign div_ge  = (rem_reg >= {1'b0, den_reg});
    assign rem_sub = div_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.seg_latch)
        begin
            rem_reg <= num_seg;
            den_reg <= den_seg[31:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {rem_sub[31:0], 1'b0};
            quo_reg <= {quo_reg[15:0], div_ge};
        end
    end

    // Shared interpolation unit: the product is registered in prod_reg, then shifted and added in the next cycle.
    always_comb
    begin
        case (cmd.sel)
            pwfl_pkg::LERP_Y:
            begin
                lerp_a = $signed({prev_reg.y[31], prev_reg.y});
                lerp_b = $signed({cur_reg.y[31], cur_reg.y});
            end
            pwfl_pkg::LERP_H:
            begin
                lerp_a = $signed({prev_reg.h[31], prev_reg.h});
                lerp_b = $signed({cur_reg.h[31], cur_reg.h});
            end
            pwfl_pkg::LERP_LO:
            begin
                lerp_a = $signed({17'd0, prev_reg.slo});
                lerp_b = $signed({17'd0, cur_reg.slo});
            end
            default:
            begin
                lerp_a = $signed({17'd0, prev_reg.shi});
                lerp_b = $signed({17'd0, cur_reg.shi});
            end
        endcase
    end

    assign lerp_diff  = lerp_b - lerp_a;
    assign prod_next  = $signed({1'b0, quo_reg}) * lerp_diff;
    assign lerp_shift = prod_reg >>> pwfl_pkg::FRAC;
    assign lerp_sum   = lerp_a + $signed(lerp_shift[32:0]);
    assign y_sum      = $signed({lerp_sum[32], lerp_sum})
                      + $signed({{2{origin_y[31]}}, origin_y});
    assign hold_sum   = $signed({{2{rdata_reg.y[31]}}, rdata_reg.y})
                      + $signed({{2{origin_y[31]}}, origin_y});

    always_ff @(posedge clk)
    begin
        if (cmd.lerp_mul)
            prod_reg <= prod_next;
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.res_kind)
            pwfl_pkg::RK_PLAIN:
            begin
                res_status_reg <= cmd.res_status;
                res_y_reg      <= '0;
                res_h_reg      <= '0;
                res_lo_reg     <= '0;
                res_hi_reg     <= '0;
            end
            pwfl_pkg::RK_NOSEG:
            begin
                res_status_reg <= pwfl_pkg::ST_NOSEG;
                res_y_reg      <= origin_y;
                res_h_reg      <= '0;
                res_lo_reg     <= '0;
                res_hi_reg     <= '0;
            end
            pwfl_pkg::RK_HOLD:
            begin
                res_status_reg <= pwfl_pkg::ST_HOLD;
                res_y_reg      <= sat32(hold_sum);
                res_h_reg      <= rdata_reg.h;
                res_lo_reg     <= rdata_reg.slo;
                res_hi_reg     <= rdata_reg.shi;
            end
            pwfl_pkg::RK_INTERP:
                res_status_reg <= pwfl_pkg::ST_INTERP;
            default:
            begin
            end
        endcase
        if (cmd.lerp_add)
        begin
            case (cmd.sel)
                pwfl_pkg::LERP_Y:  res_y_reg  <= sat32(y_sum);
                pwfl_pkg::LERP_H:  res_h_reg  <= lerp_sum[31:0];
                pwfl_pkg::LERP_LO: res_lo_reg <= lerp_sum[15:0];
                default:           res_hi_reg <= lerp_sum[15:0];
            endcase
        end
    end

    // Output register; it holds a result while the next request is worked on.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_y_reg      <= res_y_reg;
            out_h_reg      <= res_h_reg;
            out_lo_reg     <= res_lo_reg;
            out_hi_reg     <= res_hi_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign floor_y        = out_y_reg;
    assign floor_height   = out_h_reg;
    assign scale_low_out  = out_lo_reg;
    assign scale_high_out = out_hi_reg;

`ifndef NO_ASSERTIONS
    // The remainder starts at or below the divisor, since P.x < q <= C.x.
    a_num_le_den: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seg_latch |=> (rem_reg <= {1'b0, den_reg}))
        else $error("interpolation numerator exceeds segment width");

    // The ratio handed to the multiplier lies in 0 .. 65536; it is zero when the
    // query sits just above a wide segment's start.
    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lerp_mul |-> (quo_reg <= 17'd65536))
        else $error("interpolation ratio out of range");

    // An accepted append grows the table by exactly one entry.
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.append && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("append did not advance the fill count");
`endif

endmodule

// ===== tb/tb_piecewise_linear_floor_lookup.sv =====
// Self-checking testbench for piecewise_linear_floor_lookup: drives append, clear and
// query requests, predicts every result in Q16.16 fixed point and checks each output field.
// Depends on pwfl_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_piecewise_linear_floor_lookup;

    // Table depth, matched to the instance parameter below.
    localparam int MAX_BP = 64;

    // The fourth operation code is not in the package: the block drops it.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // Cycles allowed for a request that gives no result to finish.
    localparam int SETTLE_CYCLES = 100;

    // Long receiver hold-off used once to back the block up.
    localparam int LONG_HOLD_CYCLES = 300;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint U32_ALL = 64'sd4294967295;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
        logic [15:0] slo;
        logic [15:0] shi;
    } floor_req_t;

    typedef struct packed {
        pwfl_pkg::status_t status;
        logic [31:0]       y;
        logic [31:0]       h;
        logic [15:0]       lo;
        logic [15:0]       hi;
    } floor_res_t;

    // Clock, reset and every block input start at known values.
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         operation = 2'd0;
    logic signed [31:0] coord_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_height = '0;
    logic [15:0]        point_scale_low = '0;
    logic [15:0]        point_scale_high = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         status;
    logic signed [31:0] floor_y;
    logic signed [31:0] floor_height;
    logic [15:0]        scale_low_out;
    logic [15:0]        scale_high_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Requests waiting for the driver, and results the block still owes us.
    floor_req_t pending_reqs[$];
    floor_res_t floor_expected[$];
    floor_req_t cur_req;
    floor_res_t due_res;

    // Our own copy of the block state: origins and breakpoint table.
    longint org_x = 0;
    longint org_y = 0;
    longint bp_x[MAX_BP];
    longint bp_y[MAX_BP];
    longint bp_h[MAX_BP];
    longint bp_lo[MAX_BP];
    longint bp_hi[MAX_BP];
    int     bp_count = 0;

    int reqs_queued = 0;
    int reqs_accepted = 0;
    int phase_items = 0;
    int error_count = 0;
    int send_gap = 0;
    int ready_stall = 0;
    int long_hold_left = 0;
    bit idle_enabled = 1'b1;
    bit long_hold_req = 1'b0;
    bit long_hold_taken = 1'b0;

    piecewise_linear_floor_lookup #(
        .MAX_POINTS(MAX_BP)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .coord_x          (coord_x),
        .point_y          (point_y),
        .point_height     (point_height),
        .point_scale_low  (point_scale_low),
        .point_scale_high (point_scale_high),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .floor_y          (floor_y),
        .floor_height     (floor_height),
        .scale_low_out    (scale_low_out),
        .scale_high_out   (scale_high_out),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 clk = ~clk;

    // Clamp a wide sum into the signed 32 bit range.
    function automatic logic [31:0] sat32(input longint v);
        if (v > S32_MAX)
            return 32'h7FFF_FFFF;
        if (v < S32_MIN)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // a + floor(ratio * (b - a) / 65536); the arithmetic shift rounds toward minus infinity.
    function automatic longint lerp16(input longint a, input longint b, input longint ratio);
        return a + ((ratio * (b - a)) >>> pwfl_pkg::FRAC);
    endfunction

    // Applies one accepted request to our copy of the state and records the result it owes.
    task automatic floor_model_apply(input floor_req_t r);
        floor_res_t e;
        longint     q;
        longint     num;
        longint     den;
        longint     ratio;
        int         idx;
        int         p;
        bit         gives_result;
        e = '0;
        e.status = pwfl_pkg::ST_DONE;
        gives_result = 1'b1;
        case (r.op)
            pwfl_pkg::OP_APPEND:
            begin
                if (bp_count >= MAX_BP)
                    e.status = pwfl_pkg::ST_FULL;
                else
                begin
                    bp_x[bp_count] = longint'($signed(r.x));
                    bp_y[bp_count] = longint'($signed(r.y));
                    bp_h[bp_count] = longint'($signed(r.h));
                    bp_lo[bp_count] = longint'(r.slo);
                    bp_hi[bp_count] = longint'(r.shi);
                    bp_count++;
                end
            end
            pwfl_pkg::OP_CLEAR:
                bp_count = 0;
            pwfl_pkg::OP_QUERY:
            begin
                // The query point is formed at full width, so it may lie outside 32 bits.
                q = longint'($signed(r.x)) - org_x;
                idx = 0;
                while (idx < bp_count && bp_x[idx] < q)
                    idx++;
                if (idx == 0)
                begin
                    e.status = pwfl_pkg::ST_NOSEG;
                    e.y = org_y[31:0];
                end
                else if (idx >= bp_count)
                begin
                    p = idx - 1;
                    e.status = pwfl_pkg::ST_HOLD;
                    e.y = sat32(bp_y[p] + org_y);
                    e.h = bp_h[p][31:0];
                    e.lo = bp_lo[p][15:0];
                    e.hi = bp_hi[p][15:0];
                end
                else
                begin
                    p = idx - 1;
                    num = q - bp_x[p];
                    den = bp_x[idx] - bp_x[p];
                    ratio = (num << pwfl_pkg::FRAC) / den;
                    e.status = pwfl_pkg::ST_INTERP;
                    e.y = sat32(lerp16(bp_y[p], bp_y[idx], ratio) + org_y);
                    e.h = 32'(lerp16(bp_h[p], bp_h[idx], ratio));
                    e.lo = 16'(lerp16(bp_lo[p], bp_lo[idx], ratio));
                    e.hi = 16'(lerp16(bp_hi[p], bp_hi[idx], ratio));
                end
            end
            default:
                gives_result = 1'b0;
        endcase
        if (gives_result)
            floor_expected.push_back(e);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_req(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] h, input logic [15:0] lo,
                             input logic [15:0] hi);
        floor_req_t r;
        r.op = op;
        r.x = x;
        r.y = y;
        r.h = h;
        r.slo = lo;
        r.shi = hi;
        pending_reqs.push_back(r);
        reqs_queued++;
        if (op != OP_IGNORED)
            phase_items++;
    endtask

    // Configuration write with a setup and an access phase; the register takes the value at the access edge.
    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == pwfl_pkg::REG_ORIGIN_X)
            org_x = longint'($signed(data));
        else
            org_y = longint'($signed(data));
    endtask

    // Waits until every request has been taken and answered, then lets a request that
    // gives no result run out before anything else touches the block.
    task automatic wait_all_done();
        do
            @(posedge clk);
        while (reqs_accepted != reqs_queued || floor_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One well-formed run: usually a clear, then breakpoints with non-decreasing x and random
    // content, then queries aimed below, on, between and past the breakpoints. Targets
    // are placed in query space, so the current x origin is added back to form coord_x.
    task automatic queue_segment_run(input bit force_full);
        int     n;
        int     k;
        int     j;
        int     pick;
        longint step_max;
        longint span;
        longint start;
        longint t;
        longint xv;
        longint xs[$];
        if (force_full)
            n = MAX_BP + 2;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                n = $urandom_range(MAX_BP - 4, MAX_BP + 4);
            else if (pick < 15)
                n = 1;
            else
                n = $urandom_range(2, 8);
        end
        case ($urandom_range(0, 3))
            0: step_max = 16;
            1: step_max = 65536;
            2: step_max = longint'(1) << 24;
            default: step_max = U32_ALL / n;
        endcase
        span = step_max * n;
        case ($urandom_range(0, 9))
            0: start = S32_MIN;
            1: start = S32_MAX - span;
            default: start = S32_MIN + (longint'($urandom) % (U32_ALL - span + 1));
        endcase
        // Now and then skip the clear so the new points land behind old ones, out of order.
        if ($urandom_range(0, 4) != 0)
            queue_req(pwfl_pkg::OP_CLEAR, $urandom, $urandom, $urandom, 16'($urandom),
                      16'($urandom));
        xv = start;
        for (j = 0; j < n; j++)
        begin
            if (j > 0)
                xv = xv + longint'($urandom_range(0, 32'(step_max)));
            xs.push_back(xv);
            queue_req(pwfl_pkg::OP_APPEND, xv[31:0], $urandom, $urandom, 16'($urandom),
                      16'($urandom));
        end
        k = $urandom_range(3, 8);
        repeat (k)
        begin
            j = $urandom_range(0, n - 1);
            case ($urandom_range(0, 4))
                0: t = xs[0] - longint'($urandom_range(0, 3));
                1: t = xs[j];
                2:
                begin
                    if (j + 1 < n)
                        t = xs[j] + (longint'($urandom) % (xs[j + 1] - xs[j] + 1));
                    else
                        t = xs[j] + 1;
                end
                3: t = xs[n - 1] + longint'($urandom_range(1, 1 << 20));
                default: t = longint'($signed($urandom));
            endcase
            xv = t + org_x;
            queue_req(pwfl_pkg::OP_QUERY, xv[31:0], $urandom, $urandom, 16'($urandom),
                      16'($urandom));
        end
    endtask

    // Driver. A new request goes out only once the previous one has been taken, so the
    // payload never moves while valid is high. Random gaps follow some requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                floor_model_apply(cur_req);
                reqs_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    operation <= cur_req.op;
                    coord_x <= cur_req.x;
                    point_y <= cur_req.y;
                    point_height <= cur_req.h;
                    point_scale_low <= cur_req.slo;
                    point_scale_high <= cur_req.shi;
                    if (idle_enabled && $urandom_range(0, 99) < 10)
                        send_gap = $urandom_range(1, 11);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor. Every result taken is checked against the oldest expectation. Ready drops
    // in short random bursts, and once for a long stretch so that the block fills up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_stall = 0;
            long_hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (floor_expected.size() == 0)
                begin
                    $display("%0t ns: result with no request waiting, expected none, %s %0d",
                             $time, "actual status", status);
                    error_count++;
                end
                else
                begin
                    due_res = floor_expected.pop_front();
                    report_field("status", 32'(due_res.status), 32'(status));
                    report_field("floor_y", due_res.y, floor_y);
                    report_field("floor_height", due_res.h, floor_height);
                    report_field("scale_low_out", 32'(due_res.lo), 32'(scale_low_out));
                    report_field("scale_high_out", 32'(due_res.hi), 32'(scale_high_out));
                end
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_req && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                long_hold_left = LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (ready_stall > 0)
            begin
                ready_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_enabled && $urandom_range(0, 99) < 10)
                    ready_stall = $urandom_range(1, 11);
            end
        end
    end

    // Stimulus: directed checks under three origin settings, then random phases. Every
    // origin change happens with the block idle, after all results are in.
    initial
    begin
        logic [31:0] ox;
        logic [31:0] oy;
        int          phase;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        apb_write(pwfl_pkg::REG_ORIGIN_X, 32'h0000_0000);
        apb_write(pwfl_pkg::REG_ORIGIN_Y, 32'h0000_0000);

        // Empty table gives no segment; the unused operation code is dropped.
        queue_req(pwfl_pkg::OP_QUERY, 32'h0000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        // Breakpoints at the x extremes with extreme content.
        queue_req(pwfl_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  16'h0000, 16'hFFFF);
        queue_req(pwfl_pkg::OP_APPEND, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'hFFFF, 16'h0000);
        queue_req(pwfl_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h0064_0000, 32'h0005_0000,
                  16'h0100, 16'h0200);
        // On the first point is still no segment; just above it the ratio is tiny.
        queue_req(pwfl_pkg::OP_QUERY, 32'h8000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h8000_0001, 32'h0, 32'h0, 16'h0, 16'h0);
        // Exactly on a later point the ratio is one.
        queue_req(pwfl_pkg::OP_QUERY, 32'h0000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h4000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0);
        // A point out of order is still scanned in stored order.
        queue_req(pwfl_pkg::OP_APPEND, 32'hC000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                  16'h1234, 16'h4321);
        queue_req(pwfl_pkg::OP_QUERY, 32'hD000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h0000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        // A single point: anything above it holds its values.
        queue_req(pwfl_pkg::OP_APPEND, 32'h0001_0000, 32'h0100_0000, 32'h0002_0000,
                  16'h0080, 16'h0300);
        queue_req(pwfl_pkg::OP_QUERY, 32'h0002_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        wait_all_done();

        // Extreme origins, first way round: the query point reaches 2^32 - 1 and the
        // held y saturates high.
        apb_write(pwfl_pkg::REG_ORIGIN_X, 32'h8000_0000);
        apb_write(pwfl_pkg::REG_ORIGIN_Y, 32'h7FFF_FFFF);
        queue_req(pwfl_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h8000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_0000, 32'h0, 16'hFFFF,
                  16'hFFFF);
        queue_req(pwfl_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0);
        wait_all_done();

        // The other way round: the query point drops far below the table, y saturates low,
        // and interpolation between negative values checks rounding toward minus infinity.
        apb_write(pwfl_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
        apb_write(pwfl_pkg::REG_ORIGIN_Y, 32'h8000_0000);
        queue_req(pwfl_pkg::OP_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                  16'hFFFF, 16'hFFFF);
        queue_req(pwfl_pkg::OP_APPEND, 32'hFFFF_FFFF, 32'hFFFB_0000, 32'h8000_0001,
                  16'h0001, 16'h0000);
        queue_req(pwfl_pkg::OP_QUERY, 32'h8000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h7FFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0);
        queue_req(pwfl_pkg::OP_QUERY, 32'h0000_0000, 32'h0, 32'h0, 16'h0, 16'h0);
        wait_all_done();

        // Random phases, mostly well-formed runs with some noise. The first one fills the
        // table past its end and starts the long receiver hold-off; the third runs without
        // idling, and so does the last part of the run.
        for (phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    ox = 32'h0;
                    oy = 32'h0;
                end
                1:
                begin
                    ox = 32'($signed($urandom) >>> 11);
                    oy = 32'($signed($urandom) >>> 11);
                end
                2:
                begin
                    ox = $urandom;
                    oy = $urandom;
                end
                default:
                begin
                    ox = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    oy = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
            endcase
            apb_write(pwfl_pkg::REG_ORIGIN_X, ox);
            apb_write(pwfl_pkg::REG_ORIGIN_Y, oy);
            idle_enabled = (phase != 2 && phase != 5);
            phase_items = 0;
            if (phase == 0)
            begin
                queue_segment_run(1'b1);
                long_hold_req <= 1'b1;
            end
            while (phase_items < 270)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_segment_run(1'b0);
                else
                    queue_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                              16'($urandom), 16'($urandom));
            end
            wait_all_done();
        end

        if (error_count == 0 && floor_expected.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
